### design/assert_macros.svh
// Assertion macros shared by the RTL of the time request retry controller.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in every cycle in which ante holds.
`define TRC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cond never holds.
`define TRC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

### design/trc_pkg.sv
// Shared types and constants of the time request retry controller.
// No dependencies; used by trc_core and time_request_retry_controller.
package trc_pkg;

  localparam int ID_BITS_DEF = 16;

  localparam logic [31:0] SYNC_INTERVAL_RST   = 32'd3600000;
  localparam logic [31:0] REQUEST_TIMEOUT_RST = 32'd15000;
  localparam logic [31:0] RETRY_DELAY_RST     = 32'd3000;
  localparam logic [3:0]  MAX_ATTEMPTS_RST    = 4'd3;
  localparam logic [3:0]  ATTEMPT_CAP         = 4'd15;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_SESSION    = 3'd1,
    OP_ROUND      = 3'd2,
    OP_RESPONSE   = 3'd3,
    OP_DISCONNECT = 3'd4,
    OP_BEGIN      = 3'd5
  } trc_op_t;

  typedef enum logic [2:0] {
    CFG_SYNC_INTERVAL   = 3'd0,
    CFG_REQUEST_TIMEOUT = 3'd1,
    CFG_RETRY_DELAY     = 3'd2,
    CFG_MAX_ATTEMPTS    = 3'd3
  } trc_cfg_idx_t;

  typedef struct packed {
    logic [31:0] sync_interval;
    logic [31:0] request_timeout;
    logic [31:0] retry_delay;
    logic [3:0]  max_attempts;
  } trc_cfg_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] now_ms;
    logic [15:0] peer_id;
    logic        peer_supported;
    logic        task_enabled;
    logic        has_synced;
    logic        send_ok;
    logic        is_time_response;
    logic [15:0] response_id;
    logic        response_ok;
  } trc_item_t;

  typedef struct packed {
    logic        session_ready;
    logic        session_supported;
    logic        peer_known;
    logic [15:0] current_peer;
    logic        success_peer_valid;
    logic [15:0] success_peer;
    logic        sync_needed;
    logic        outstanding;
    logic [31:0] started_time;
    logic [31:0] failed_time;
    logic        retry_pending;
    logic [3:0]  attempt_count;
    logic [31:0] success_age;
    logic [31:0] last_age_time;
  } trc_state_t;

  typedef struct packed {
    logic        send_request;
    logic [15:0] request_id;
    logic        cancel_request;
    logic [15:0] cancel_id;
    logic        trigger_now;
    logic        sync_done;
    logic        message_consumed;
    logic        needs_sync_flag;
    logic        busy_res;
    logic        retry_waiting;
  } trc_res_t;

endpackage

### design/trc_core.sv
// Next-state and result logic for one event of the time request retry controller.
// Purely combinational; uses types from trc_pkg.
module trc_core #(
  parameter int ID_BITS = trc_pkg::ID_BITS_DEF
) (
  input  trc_pkg::trc_cfg_t   cfg,
  input  trc_pkg::trc_item_t  item,
  input  trc_pkg::trc_state_t st,
  input  logic [ID_BITS-1:0]  out_id,
  input  logic [ID_BITS-1:0]  next_id,
  output trc_pkg::trc_state_t st_next,
  output logic [ID_BITS-1:0]  out_id_next,
  output logic [ID_BITS-1:0]  next_id_next,
  output trc_pkg::trc_res_t   res
);

  localparam int CMP_W = (ID_BITS > 16) ? ID_BITS : 16;

  function automatic logic [15:0] id_low(input logic [ID_BITS-1:0] id);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(id);
    return ext[15:0];
  endfunction

  trc_pkg::trc_state_t s;
  trc_pkg::trc_res_t   r;
  logic [ID_BITS-1:0]  oid;
  logic [ID_BITS-1:0]  nid;
  logic [ID_BITS-1:0]  att_id;
  logic [31:0]         elapsed;
  logic [31:0]         room;
  logic [31:0]         aged;
  logic                timed_out;
  logic                retry_due;
  logic                peer_diff;
  logic                changed;
  logic                do_att;

  // Age of the last success, clamped at the interval.
  always_comb begin
    elapsed = item.now_ms - st.last_age_time;
    room    = cfg.sync_interval - st.success_age;
    if (st.success_age >= cfg.sync_interval) begin
      aged = cfg.sync_interval;
    end else begin
      aged = st.success_age + ((elapsed < room) ? elapsed : room);
    end
  end

  always_comb begin
    s         = st;
    r         = '0;
    oid       = out_id;
    nid       = next_id;
    att_id    = next_id;
    do_att    = 1'b0;
    timed_out = (item.now_ms - st.started_time) >= cfg.request_timeout;
    retry_due = 1'b0;
    peer_diff = !st.peer_known || (st.current_peer != item.peer_id);
    changed   = !st.session_ready || peer_diff || (!st.session_supported && item.peer_supported);

    case (item.opcode)
      trc_pkg::OP_TICK: begin
        if (item.has_synced) begin
          s.success_age = aged;
          if (aged == cfg.sync_interval) s.sync_needed = 1'b1;
        end
        s.last_age_time = item.now_ms;
        retry_due = (item.now_ms - st.failed_time) >= cfg.retry_delay;
        if (s.outstanding && timed_out) begin
          r.cancel_request = 1'b1;
          r.cancel_id      = id_low(oid);
          s.outstanding    = 1'b0;
          s.sync_needed    = 1'b1;
          s.failed_time    = item.now_ms;
          s.retry_pending  = s.attempt_count < cfg.max_attempts;
          // failure stamped now: zero elapsed since it
          retry_due        = (cfg.retry_delay == 32'd0);
        end
        if (!item.task_enabled) begin
          s.retry_pending = 1'b0;
        end else if (s.retry_pending && s.session_ready && s.session_supported && retry_due) begin
          s.retry_pending = 1'b0;
          do_att          = 1'b1;
        end
      end
      trc_pkg::OP_SESSION: begin
        if (item.has_synced) begin
          s.success_age = aged;
          if (aged == cfg.sync_interval) s.sync_needed = 1'b1;
        end
        s.last_age_time = item.now_ms;
        if (peer_diff || (st.session_supported && !item.peer_supported)) begin
          if (s.outstanding) begin
            s.sync_needed    = 1'b1;
            r.cancel_request = 1'b1;
            r.cancel_id      = id_low(oid);
          end
          s.outstanding   = 1'b0;
          s.retry_pending = 1'b0;
        end
        s.session_ready      = 1'b1;
        s.session_supported  = item.peer_supported;
        s.current_peer       = item.peer_id;
        s.peer_known         = 1'b1;
        if (!item.has_synced || !st.success_peer_valid || (st.success_peer != item.peer_id)) begin
          s.sync_needed = 1'b1;
        end
        r.trigger_now = changed && s.sync_needed && item.peer_supported && item.task_enabled;
      end
      trc_pkg::OP_ROUND: begin
        s.sync_needed = 1'b1;
        if (item.task_enabled && st.session_ready && st.session_supported &&
            !st.outstanding && !st.retry_pending) begin
          s.attempt_count = 4'd0;
          do_att          = 1'b1;
        end
      end
      trc_pkg::OP_RESPONSE: begin
        if (item.is_time_response && st.outstanding &&
            (CMP_W'(item.response_id) == CMP_W'(out_id))) begin
          r.message_consumed = 1'b1;
          s.outstanding      = 1'b0;
          if (!item.response_ok) begin
            r.cancel_request = 1'b1;
            r.cancel_id      = id_low(oid);
            s.sync_needed    = 1'b1;
            s.failed_time    = item.now_ms;
            s.retry_pending  = st.attempt_count < cfg.max_attempts;
          end else begin
            s.sync_needed        = 1'b0;
            s.retry_pending      = 1'b0;
            s.success_peer       = st.current_peer;
            s.success_peer_valid = st.peer_known;
            s.success_age        = 32'd0;
            s.last_age_time      = item.now_ms;
            r.sync_done          = 1'b1;
          end
        end
      end
      trc_pkg::OP_DISCONNECT: begin
        if (st.outstanding) begin
          s.sync_needed    = 1'b1;
          r.cancel_request = 1'b1;
          r.cancel_id      = id_low(oid);
        end
        s.outstanding       = 1'b0;
        s.retry_pending     = 1'b0;
        s.session_ready     = 1'b0;
        s.session_supported = 1'b0;
      end
      trc_pkg::OP_BEGIN: begin
        if (item.task_enabled) s.last_age_time = item.now_ms;
      end
      default: begin
      end
    endcase

    // A new attempt always comes last in its event; it takes an id even if the send fails.
    if (do_att) begin
      if (s.attempt_count < trc_pkg::ATTEMPT_CAP) s.attempt_count = s.attempt_count + 4'd1;
      att_id = nid;
      nid    = nid + ID_BITS'(1);
      if (!item.send_ok) begin
        if (s.outstanding) begin
          r.cancel_request = 1'b1;
          r.cancel_id      = id_low(oid);
        end
        s.outstanding   = 1'b0;
        s.sync_needed   = 1'b1;
        s.failed_time   = item.now_ms;
        s.retry_pending = s.attempt_count < cfg.max_attempts;
      end else begin
        s.outstanding  = 1'b1;
        oid            = att_id;
        s.started_time = item.now_ms;
        r.send_request = 1'b1;
        r.request_id   = id_low(att_id);
      end
    end

    r.needs_sync_flag = s.sync_needed;
    r.busy_res        = s.outstanding;
    r.retry_waiting   = s.retry_pending;

    st_next      = s;
    res          = r;
    out_id_next  = oid;
    next_id_next = nid;
  end

endmodule

### design/time_request_retry_controller.sv
// Top level of the time request retry controller: handshakes, registers, state.
// Depends on trc_pkg, trc_core and assert_macros.svh.
//
// Usage:
//   Input channel: in_valid with the event fields, in_stall back to the sender.
//   An event is taken at a clock edge with in_valid high and in_stall low.
//   Output channel: out_valid with one result per event, out_stall from the
//   receiver; a result is taken at an edge with out_valid high, out_stall low.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Write only while no event is in flight.
//   Path: an event is held in the input register, then its result word in the
//   result register. Throughput: one event per cycle while out_stall stays
//   low, set by the single-pass update of the controller state between
//   those registers.
//   Stall: while a result waits, one more event is taken into the input
//   register; after that in_stall rises until the result is taken.
//   Reset (rst, synchronous): empties both registers, loads the default
//   configuration and clears all controller state, ids included.
module time_request_retry_controller #(
  parameter int ID_BITS = trc_pkg::ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [31:0] now_ms,
  input  logic [15:0] peer_id,
  input  logic        peer_supported,
  input  logic        task_enabled,
  input  logic        has_synced,
  input  logic        send_ok,
  input  logic        is_time_response,
  input  logic [15:0] response_id,
  input  logic        response_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        send_request,
  output logic [15:0] request_id,
  output logic        cancel_request,
  output logic [15:0] cancel_id,
  output logic        trigger_now,
  output logic        sync_done,
  output logic        message_consumed,
  output logic        needs_sync_flag,
  output logic        busy_res,
  output logic        retry_waiting,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

`include "assert_macros.svh"

  trc_pkg::trc_cfg_t   cfg;
  trc_pkg::trc_state_t st;
  trc_pkg::trc_state_t st_next;
  logic [ID_BITS-1:0]  out_id;
  logic [ID_BITS-1:0]  out_id_next;
  logic [ID_BITS-1:0]  next_id;
  logic [ID_BITS-1:0]  next_id_next;
  trc_pkg::trc_item_t  item;
  logic                in_full;
  trc_pkg::trc_res_t   res_next;
  trc_pkg::trc_res_t   res;
  logic                out_full;
  logic                advance;
  logic                in_take;

  assign cfg_ready = 1'b1;

  // Move the held event into the result register when that register frees up.
  assign advance  = in_full && (!out_full || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_interval   <= trc_pkg::SYNC_INTERVAL_RST;
      cfg.request_timeout <= trc_pkg::REQUEST_TIMEOUT_RST;
      cfg.retry_delay     <= trc_pkg::RETRY_DELAY_RST;
      cfg.max_attempts    <= trc_pkg::MAX_ATTEMPTS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        trc_pkg::CFG_SYNC_INTERVAL:   cfg.sync_interval   <= cfg_data;
        trc_pkg::CFG_REQUEST_TIMEOUT: cfg.request_timeout <= cfg_data;
        trc_pkg::CFG_RETRY_DELAY:     cfg.retry_delay     <= cfg_data;
        trc_pkg::CFG_MAX_ATTEMPTS:    cfg.max_attempts    <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.opcode           <= opcode;
      item.now_ms           <= now_ms;
      item.peer_id          <= peer_id;
      item.peer_supported   <= peer_supported;
      item.task_enabled     <= task_enabled;
      item.has_synced       <= has_synced;
      item.send_ok          <= send_ok;
      item.is_time_response <= is_time_response;
      item.response_id      <= response_id;
      item.response_ok      <= response_ok;
    end
  end

  trc_core #(
    .ID_BITS(ID_BITS)
  ) u_core (
    .cfg         (cfg),
    .item        (item),
    .st          (st),
    .out_id      (out_id),
    .next_id     (next_id),
    .st_next     (st_next),
    .out_id_next (out_id_next),
    .next_id_next(next_id_next),
    .res         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= '0;
      out_id  <= '0;
      next_id <= '0;
    end else if (advance) begin
      st      <= st_next;
      out_id  <= out_id_next;
      next_id <= next_id_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res <= res_next;
  end

  assign out_valid        = out_full;
  assign send_request     = res.send_request;
  assign request_id       = res.request_id;
  assign cancel_request   = res.cancel_request;
  assign cancel_id        = res.cancel_id;
  assign trigger_now      = res.trigger_now;
  assign sync_done        = res.sync_done;
  assign message_consumed = res.message_consumed;
  assign needs_sync_flag  = res.needs_sync_flag;
  assign busy_res         = res.busy_res;
  assign retry_waiting    = res.retry_waiting;

  `TRC_ASSERT_NEVER(a_busy_xor_retry, st.outstanding && st.retry_pending,
                    "request outstanding while a retry waits")
  `TRC_ASSERT_IMP(a_send_busy, out_full && res.send_request, res.busy_res,
                  "send without an outstanding request")
  `TRC_ASSERT_IMP(a_done_clean, out_full && res.sync_done,
                  res.message_consumed && !res.busy_res && !res.retry_waiting &&
                  !res.needs_sync_flag, "success leaves stale state")
  `TRC_ASSERT_IMP(a_send_id_taken, advance && res_next.send_request,
                  next_id_next != next_id, "request sent without taking an id")

endmodule
